// File: hw/rtl/gdma_pkg.sv
// ----------------------------------------------------------------------------
// gdma_pkg: shared definitions of the grouped daily mean aggregator
// Widths, codes, the state type and the variable count used by the interfaces, top and bench.
// ----------------------------------------------------------------------------
package gdma_pkg;

   // number of daily variables per day record
   localparam int NUM_VARS = 16;

   // variable address and flush counter widths
   localparam int VA_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
   localparam int VC_W = $clog2(NUM_VARS + 1);

   // field widths
   localparam int PID_W = 32;
   localparam int VAL_W = 32;
   localparam int SUM_W = 40;
   localparam int CNT_W = 8;
   localparam int VAR_W = 4;
   localparam int DOW_W = 3;
   localparam int ENT_W = 3 * SUM_W;

   // divider step counter
   localparam int DSC_W = $clog2(SUM_W + 1);

   localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [VAL_W-1:0] MEAN_MAX = {VAL_W{1'b1}};

   // weekend day numbers
   localparam logic [DOW_W-1:0] DOW_FIRST = 3'd1;
   localparam logic [DOW_W-1:0] DOW_LAST  = 3'd7;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WEEKDAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WEEKEND = 2'd2;

   typedef enum logic [1:0] {
      KIND_SUMMARY = 2'd0,
      KIND_ALL     = 2'd1,
      KIND_WEEKDAY = 2'd2,
      KIND_WEEKEND = 2'd3
   } gdma_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_ACC_WRITE,
      ST_SUMMARY,
      ST_FL_READ,
      ST_FL_LOAD,
      ST_FL_DIV,
      ST_FL_OUT
   } gdma_state_type;

endpackage

// File: hw/rtl/gdma_if.sv
// ----------------------------------------------------------------------------
// gdma channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface gdma_req_if
   import gdma_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PID_W-1:0] person_id;
   logic [DOW_W-1:0] day_of_week;
   logic             day_valid;
   logic [VAR_W-1:0] var_index;
   logic [VAL_W-1:0] value;
   logic             end_of_data;

   modport source (output valid, person_id, day_of_week, day_valid, var_index, value,
                   end_of_data, input ready);
   modport sink   (input valid, person_id, day_of_week, day_valid, var_index, value,
                   end_of_data, output ready);
endinterface

interface gdma_rsp_if
   import gdma_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PID_W-1:0] out_person_id;
   logic [1:0]       kind;
   logic [VAR_W-1:0] out_var_index;
   logic [VAL_W-1:0] mean;
   logic             mean_undefined;
   logic [CNT_W-1:0] valid_day_count;
   logic [CNT_W-1:0] weekday_count;
   logic [CNT_W-1:0] weekend_count;
   logic             qualifies;
   logic             last;

   modport source (output valid, out_person_id, kind, out_var_index, mean, mean_undefined,
                   valid_day_count, weekday_count, weekend_count, qualifies, last,
                   input ready);
   modport sink   (input valid, out_person_id, kind, out_var_index, mean, mean_undefined,
                   valid_day_count, weekday_count, weekend_count, qualifies, last,
                   output ready);
endinterface

interface gdma_csr_if
   import gdma_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CNT_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gdma_ram.sv
// ----------------------------------------------------------------------------
// gdma_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gdma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/grouped_daily_mean_aggregator_top.sv
// ----------------------------------------------------------------------------
// grouped_daily_mean_aggregator_top: per-person daily variable means
// Counts valid days, accumulates per-variable sums and, on a person change
// or end marker, emits a summary and all-days, weekday and weekend means.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  req_ch   in         person_id, day_of_week, day_valid, var_index, value, end_of_data
//  rsp_ch   out        summary or mean result, last marks end of a flush
//  csr_ch   in         index 0..2 min_valid/min_weekday/min_weekend, always ready
//
//  A request without a flush passes accept, a read of the sum RAM and a write back.
//  A flush adds 1 + 3*NUM_VARS results; each mean passes a RAM read, a load and the
//  one-bit-per-cycle divider (40 steps for a 40-bit sum).
//  Reset is synchronous; it clears counts, person state and the entry valid bits
//  (no clearing pass). A stalled result holds only the result register; the
//  divider keeps working until the next result is ready to load.
// ----------------------------------------------------------------------------
module grouped_daily_mean_aggregator_top
   import gdma_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   gdma_req_if.sink   req_ch,
   gdma_rsp_if.source rsp_ch,
   gdma_csr_if.sink   csr_ch
);

   gdma_state_type state_ff, state_in;

   // configuration
   logic [CNT_W-1:0] min_valid_ff, min_valid_in;
   logic [CNT_W-1:0] min_wd_ff, min_wd_in;
   logic [CNT_W-1:0] min_we_ff, min_we_in;

   // person state
   logic [PID_W-1:0] cur_pid_ff, cur_pid_in;
   logic             open_ff, open_in;
   logic [CNT_W-1:0] cnt_all_ff, cnt_all_in;
   logic [CNT_W-1:0] cnt_wd_ff, cnt_wd_in;
   logic [CNT_W-1:0] cnt_we_ff, cnt_we_in;
   logic [NUM_VARS-1:0] ent_valid_ff, ent_valid_in;

   // captured request
   logic [PID_W-1:0] it_pid_ff, it_pid_in;
   logic [DOW_W-1:0] it_dow_ff, it_dow_in;
   logic             it_dv_ff, it_dv_in;
   logic [VAR_W-1:0] it_var_ff, it_var_in;
   logic [VAL_W-1:0] it_val_ff, it_val_in;
   logic             resume_ff, resume_in;

   // flush sequencing and divider
   gdma_kind_type    fkind_ff, fkind_in;
   logic [VC_W-1:0]  fvar_ff, fvar_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [DSC_W-1:0] step_ff, step_in;
   logic             undef_ff, undef_in;

   // result register
   logic             rv_ff, rv_in;
   logic [PID_W-1:0] r_pid_ff, r_pid_in;
   gdma_kind_type    r_kind_ff, r_kind_in;
   logic [VAR_W-1:0] r_var_ff, r_var_in;
   logic [VAL_W-1:0] r_mean_ff, r_mean_in;
   logic             r_undef_ff, r_undef_in;
   logic [CNT_W-1:0] r_ca_ff, r_ca_in;
   logic [CNT_W-1:0] r_cwd_ff, r_cwd_in;
   logic [CNT_W-1:0] r_cwe_ff, r_cwe_in;
   logic             r_q_ff, r_q_in;
   logic             r_last_ff, r_last_in;

   // RAM ports
   logic             ram_we, ram_re;
   logic [VA_W-1:0]  ram_wa, ram_ra;
   logic [ENT_W-1:0] ram_wd, ram_rd;

   // helpers
   logic [7:0]       it_var_ext, fvar_ext;
   logic [VA_W-1:0]  it_addr, f_addr;
   logic             it_in_range, it_weekend;
   logic [ENT_W-1:0] ent_rd;
   logic [SUM_W:0]   add_all, add_wd, add_we;
   logic [SUM_W-1:0] s_all, s_wd, s_we, f_sum;
   logic [CNT_W-1:0] f_cnt;
   logic [CNT_W:0]   rem_sh, rem_diff;
   logic             rem_ge, out_free, f_last;

   gdma_ram #(.WIDTH(ENT_W), .DEPTH(NUM_VARS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // decode captured request and flush position
   assign it_var_ext  = 8'(it_var_ff);
   assign it_addr     = it_var_ext[VA_W-1:0];
   assign it_in_range = it_var_ext < 8'(NUM_VARS);
   assign it_weekend  = (it_dow_ff == DOW_FIRST) || (it_dow_ff == DOW_LAST);
   assign fvar_ext    = 8'(fvar_ff);
   assign f_addr      = fvar_ff[VA_W-1:0];
   assign f_last      = (fkind_ff == KIND_WEEKEND) && (fvar_ff == VC_W'(NUM_VARS - 1));
   assign out_free    = !rv_ff || rsp_ch.ready;

   // entry never written since the last flush reads as zero
   assign ent_rd = ent_valid_ff[ram_ra] ? ram_rd : '0;

   // saturating sum updates, entry packs {weekend, weekday, all}
   assign add_all = {1'b0, ent_rd[SUM_W-1:0]} + (SUM_W+1)'(it_val_ff);
   assign add_wd  = {1'b0, ent_rd[2*SUM_W-1:SUM_W]} + (SUM_W+1)'(it_val_ff);
   assign add_we  = {1'b0, ent_rd[3*SUM_W-1:2*SUM_W]} + (SUM_W+1)'(it_val_ff);
   assign s_all   = add_all[SUM_W] ? SUM_MAX : add_all[SUM_W-1:0];
   assign s_wd    = add_wd[SUM_W]  ? SUM_MAX : add_wd[SUM_W-1:0];
   assign s_we    = add_we[SUM_W]  ? SUM_MAX : add_we[SUM_W-1:0];

   // divider step
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   // pick the sum and count of the current flush kind
   always_comb begin
      unique case (fkind_ff)
         KIND_WEEKDAY: begin
            f_sum = ent_rd[2*SUM_W-1:SUM_W];
            f_cnt = cnt_wd_ff;
         end
         KIND_WEEKEND: begin
            f_sum = ent_rd[3*SUM_W-1:2*SUM_W];
            f_cnt = cnt_we_ff;
         end
         default: begin
            f_sum = ent_rd[SUM_W-1:0];
            f_cnt = cnt_all_ff;
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      min_valid_in = min_valid_ff;
      min_wd_in    = min_wd_ff;
      min_we_in    = min_we_ff;
      cur_pid_in   = cur_pid_ff;
      open_in      = open_ff;
      cnt_all_in   = cnt_all_ff;
      cnt_wd_in    = cnt_wd_ff;
      cnt_we_in    = cnt_we_ff;
      ent_valid_in = ent_valid_ff;
      it_pid_in    = it_pid_ff;
      it_dow_in    = it_dow_ff;
      it_dv_in     = it_dv_ff;
      it_var_in    = it_var_ff;
      it_val_in    = it_val_ff;
      resume_in    = resume_ff;
      fkind_in     = fkind_ff;
      fvar_in      = fvar_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      undef_in     = undef_ff;
      rv_in        = rv_ff && !rsp_ch.ready;
      r_pid_in     = r_pid_ff;
      r_kind_in    = r_kind_ff;
      r_var_in     = r_var_ff;
      r_mean_in    = r_mean_ff;
      r_undef_in   = r_undef_ff;
      r_ca_in      = r_ca_ff;
      r_cwd_in     = r_cwd_ff;
      r_cwe_in     = r_cwe_ff;
      r_q_in       = r_q_ff;
      r_last_in    = r_last_ff;
      ram_we       = 1'b0;
      ram_wa       = it_addr;
      ram_wd       = {s_we, s_wd, s_all};
      ram_re       = 1'b0;
      ram_ra       = it_addr;

      // take configuration writes
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MIN_VALID:   min_valid_in = csr_ch.data;
            CSR_MIN_WEEKDAY: min_wd_in    = csr_ch.data;
            CSR_MIN_WEEKEND: min_we_in    = csr_ch.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // capture the request and decide whether it starts a flush
            if (req_ch.valid) begin
               it_pid_in = req_ch.person_id;
               it_dow_in = req_ch.day_of_week;
               it_dv_in  = req_ch.day_valid;
               it_var_in = req_ch.var_index;
               it_val_in = req_ch.value;
               priority if (req_ch.end_of_data) begin
                  resume_in = 1'b0;
                  state_in  = open_ff ? ST_SUMMARY : ST_IDLE;
               end else if (req_ch.var_index == '0) begin
                  resume_in = 1'b1;
                  state_in  = (open_ff && req_ch.person_id != cur_pid_ff) ?
                              ST_SUMMARY : ST_APPLY;
               end else begin
                  state_in  = open_ff ? ST_APPLY : ST_IDLE;
               end
            end
         end
         ST_APPLY: begin
            // advance day counts on a record start, then read the sums
            if (it_var_ff == '0) begin
               cur_pid_in = it_pid_ff;
               open_in    = 1'b1;
               if (it_dv_ff) begin
                  cnt_all_in = (cnt_all_ff == CNT_MAX) ? CNT_MAX : cnt_all_ff + 1'b1;
                  if (it_weekend) begin
                     cnt_we_in = (cnt_we_ff == CNT_MAX) ? CNT_MAX : cnt_we_ff + 1'b1;
                  end else begin
                     cnt_wd_in = (cnt_wd_ff == CNT_MAX) ? CNT_MAX : cnt_wd_ff + 1'b1;
                  end
               end
            end
            if (it_dv_ff && it_in_range) begin
               ram_re   = 1'b1;
               state_in = ST_ACC_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACC_WRITE: begin
            // write back the updated sums of the entry
            ram_we = 1'b1;
            if (it_weekend) begin
               ram_wd = {s_we, ent_rd[2*SUM_W-1:SUM_W], s_all};
            end else begin
               ram_wd = {ent_rd[3*SUM_W-1:2*SUM_W], s_wd, s_all};
            end
            ent_valid_in[it_addr] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SUMMARY: begin
            // load the summary result
            if (out_free) begin
               rv_in      = 1'b1;
               r_pid_in   = cur_pid_ff;
               r_kind_in  = KIND_SUMMARY;
               r_var_in   = '0;
               r_mean_in  = '0;
               r_undef_in = 1'b0;
               r_ca_in    = cnt_all_ff;
               r_cwd_in   = cnt_wd_ff;
               r_cwe_in   = cnt_we_ff;
               r_q_in     = (cnt_all_ff >= min_valid_ff) && (cnt_wd_ff >= min_wd_ff) &&
                            (cnt_we_ff >= min_we_ff);
               r_last_in  = 1'b0;
               fkind_in   = KIND_ALL;
               fvar_in    = '0;
               state_in   = ST_FL_READ;
            end
         end
         ST_FL_READ: begin
            ram_re   = 1'b1;
            ram_ra   = f_addr;
            state_in = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            // start the division, or skip it on a zero count
            ram_ra  = f_addr;
            quo_in  = f_sum;
            rem_in  = '0;
            dvs_in  = f_cnt;
            step_in = '0;
            if (f_cnt == '0) begin
               quo_in   = '0;
               undef_in = 1'b1;
               state_in = ST_FL_OUT;
            end else begin
               undef_in = 1'b0;
               state_in = ST_FL_DIV;
            end
         end
         ST_FL_DIV: begin
            // one restoring step a cycle
            quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
            rem_in  = rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == DSC_W'(SUM_W - 1)) begin
               state_in = ST_FL_OUT;
            end
         end
         ST_FL_OUT: begin
            // load a mean result and advance the flush
            if (out_free) begin
               rv_in      = 1'b1;
               r_pid_in   = cur_pid_ff;
               r_kind_in  = fkind_ff;
               r_var_in   = fvar_ext[VAR_W-1:0];
               r_mean_in  = (quo_ff[SUM_W-1:VAL_W] != '0) ? MEAN_MAX : quo_ff[VAL_W-1:0];
               r_undef_in = undef_ff;
               r_ca_in    = '0;
               r_cwd_in   = '0;
               r_cwe_in   = '0;
               r_q_in     = 1'b0;
               r_last_in  = f_last;
               if (f_last) begin
                  cnt_all_in   = '0;
                  cnt_wd_in    = '0;
                  cnt_we_in    = '0;
                  ent_valid_in = '0;
                  if (resume_ff) begin
                     state_in = ST_APPLY;
                  end else begin
                     open_in  = 1'b0;
                     state_in = ST_IDLE;
                  end
               end else begin
                  if (fvar_ff == VC_W'(NUM_VARS - 1)) begin
                     fvar_in  = '0;
                     fkind_in = gdma_kind_type'(fkind_ff + 2'd1);
                  end else begin
                     fvar_in  = fvar_ff + 1'b1;
                  end
                  state_in = ST_FL_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_valid_ff <= 8'd1;
         min_wd_ff    <= '0;
         min_we_ff    <= '0;
         cur_pid_ff   <= '0;
         open_ff      <= 1'b0;
         cnt_all_ff   <= '0;
         cnt_wd_ff    <= '0;
         cnt_we_ff    <= '0;
         ent_valid_ff <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_valid_ff <= min_valid_in;
         min_wd_ff    <= min_wd_in;
         min_we_ff    <= min_we_in;
         cur_pid_ff   <= cur_pid_in;
         open_ff      <= open_in;
         cnt_all_ff   <= cnt_all_in;
         cnt_wd_ff    <= cnt_wd_in;
         cnt_we_ff    <= cnt_we_in;
         ent_valid_ff <= ent_valid_in;
         rv_ff        <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      it_pid_ff  <= it_pid_in;
      it_dow_ff  <= it_dow_in;
      it_dv_ff   <= it_dv_in;
      it_var_ff  <= it_var_in;
      it_val_ff  <= it_val_in;
      resume_ff  <= resume_in;
      fkind_ff   <= fkind_in;
      fvar_ff    <= fvar_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      step_ff    <= step_in;
      undef_ff   <= undef_in;
      r_pid_ff   <= r_pid_in;
      r_kind_ff  <= r_kind_in;
      r_var_ff   <= r_var_in;
      r_mean_ff  <= r_mean_in;
      r_undef_ff <= r_undef_in;
      r_ca_ff    <= r_ca_in;
      r_cwd_ff   <= r_cwd_in;
      r_cwe_ff   <= r_cwe_in;
      r_q_ff     <= r_q_in;
      r_last_ff  <= r_last_in;
   end

   // drive the channels
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid           = rv_ff;
   assign rsp_ch.out_person_id   = r_pid_ff;
   assign rsp_ch.kind            = r_kind_ff;
   assign rsp_ch.out_var_index   = r_var_ff;
   assign rsp_ch.mean            = r_mean_ff;
   assign rsp_ch.mean_undefined  = r_undef_ff;
   assign rsp_ch.valid_day_count = r_ca_ff;
   assign rsp_ch.weekday_count   = r_cwd_ff;
   assign rsp_ch.weekend_count   = r_cwe_ff;
   assign rsp_ch.qualifies       = r_q_ff;
   assign rsp_ch.last            = r_last_ff;

endmodule

// File: dv/tb_grouped_daily_mean_aggregator_top.sv
// ----------------------------------------------------------------------------
// tb_grouped_daily_mean_aggregator_top: self-checking bench of the aggregator
// Streams per-person day records through the block, predicts every summary and
// mean result in the bench, and checks each result in order, field by field.
// ----------------------------------------------------------------------------
module tb_grouped_daily_mean_aggregator_top
   import gdma_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 500;
   localparam int SETTLE_CYCLES  = 60;

   typedef struct {
      logic [PID_W-1:0] pid;
      logic [DOW_W-1:0] dow;
      logic             dv;
      logic [VAR_W-1:0] vi;
      logic [VAL_W-1:0] val;
      logic             eod;
   } day_item_type;

   typedef struct {
      logic [PID_W-1:0] pid;
      gdma_kind_type    kind;
      logic [VAR_W-1:0] vi;
      logic [VAL_W-1:0] mean;
      logic             undef;
      logic [CNT_W-1:0] ca;
      logic [CNT_W-1:0] cwd;
      logic [CNT_W-1:0] cwe;
      logic             qual;
      logic             last;
   } agg_result_type;

   logic clock;
   logic reset;

   gdma_req_if req_if ();
   gdma_rsp_if rsp_if ();
   gdma_csr_if csr_if ();

   grouped_daily_mean_aggregator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   // bench copy of the aggregator state and thresholds
   logic [SUM_W-1:0] acc_all [NUM_VARS];
   logic [SUM_W-1:0] acc_wd  [NUM_VARS];
   logic [SUM_W-1:0] acc_we  [NUM_VARS];
   logic [CNT_W-1:0] days_all, days_wd, days_we;
   logic [CNT_W-1:0] thr_valid, thr_wd, thr_we;
   logic [PID_W-1:0] open_pid;
   logic             pid_open;

   day_item_type   pending_q [$];
   agg_result_type expected_q [$];

   int  fail_cnt;
   int  gap_left;
   int  stall_left;
   int  hold_left;
   bit  start_hold;
   bit  no_idle;
   int  quiet_cycles;
   bit  any_accept;
   agg_result_type got, exp_r;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, logic [VAL_W-1:0] v);
      logic [SUM_W:0] r;
      r = {1'b0, s} + v;
      return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_cnt(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   function automatic agg_result_type mean_result(gdma_kind_type k, int v,
                                                  logic [SUM_W-1:0] s,
                                                  logic [CNT_W-1:0] c);
      agg_result_type r;
      logic [SUM_W-1:0] q;
      r = '{pid: open_pid, kind: k, vi: v[VAR_W-1:0], mean: '0, undef: 1'b1,
            ca: '0, cwd: '0, cwe: '0, qual: 1'b0, last: 1'b0};
      if (c != 0) begin
         q = s / c;
         r.mean  = (q > {8'd0, MEAN_MAX}) ? MEAN_MAX : q[VAL_W-1:0];
         r.undef = 1'b0;
      end
      return r;
   endfunction

   function automatic void clear_sums();
      for (int v = 0; v < NUM_VARS; v++) begin
         acc_all[v] = '0;
         acc_wd[v]  = '0;
         acc_we[v]  = '0;
      end
      days_all = '0;
      days_wd  = '0;
      days_we  = '0;
   endfunction

   // emit the summary and all means of the open person, then clear the sums
   function automatic void flush_person();
      agg_result_type r;
      r = '{pid: open_pid, kind: KIND_SUMMARY, vi: '0, mean: '0, undef: 1'b0,
            ca: days_all, cwd: days_wd, cwe: days_we,
            qual: (days_all >= thr_valid) && (days_wd >= thr_wd) && (days_we >= thr_we),
            last: 1'b0};
      expected_q.push_back(r);
      for (int v = 0; v < NUM_VARS; v++)
         expected_q.push_back(mean_result(KIND_ALL, v, acc_all[v], days_all));
      for (int v = 0; v < NUM_VARS; v++)
         expected_q.push_back(mean_result(KIND_WEEKDAY, v, acc_wd[v], days_wd));
      for (int v = 0; v < NUM_VARS; v++)
         expected_q.push_back(mean_result(KIND_WEEKEND, v, acc_we[v], days_we));
      expected_q[$].last = 1'b1;
      clear_sums();
   endfunction

   // advance the bench state by one accepted request
   function automatic void apply_request(day_item_type it);
      logic wknd;
      wknd = (it.dow == DOW_FIRST) || (it.dow == DOW_LAST);
      if (it.eod) begin
         if (pid_open) begin
            flush_person();
            pid_open = 1'b0;
         end
         return;
      end
      if (it.vi == 0) begin
         if (pid_open && it.pid != open_pid)
            flush_person();
         open_pid = it.pid;
         pid_open = 1'b1;
         if (it.dv) begin
            days_all = sat_cnt(days_all);
            if (wknd) days_we = sat_cnt(days_we);
            else      days_wd = sat_cnt(days_wd);
         end
      end else if (!pid_open) begin
         return;
      end
      if (it.dv && it.vi < NUM_VARS) begin
         acc_all[it.vi] = sat_sum(acc_all[it.vi], it.val);
         if (wknd) acc_we[it.vi] = sat_sum(acc_we[it.vi], it.val);
         else      acc_wd[it.vi] = sat_sum(acc_wd[it.vi], it.val);
      end
   endfunction

   function automatic void check_field(string name, logic [SUM_W-1:0] e, logic [SUM_W-1:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, a);
         fail_cnt++;
      end
   endfunction

   // request driver: hold the item until accepted, then advance or idle a burst
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0 || pending_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            req_if.person_id   <= pending_q[0].pid;
            req_if.day_of_week <= pending_q[0].dow;
            req_if.day_valid   <= pending_q[0].dv;
            req_if.var_index   <= pending_q[0].vi;
            req_if.value       <= pending_q[0].val;
            req_if.end_of_data <= pending_q[0].eod;
            req_if.valid       <= 1'b1;
            void'(pending_q.pop_front());
            if (!no_idle && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 7);
         end
      end
   end

   // result sink: long hold-off on request, else random stall bursts
   always @(posedge clock) begin
      if (start_hold) begin
         hold_left  = HOLD_CYCLES;
         start_hold = 1'b0;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
      end
   end

   // predict on accepted requests, check accepted results, watch for a hang
   always @(posedge clock) begin
      any_accept = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            apply_request('{pid: req_if.person_id, dow: req_if.day_of_week,
                            dv: req_if.day_valid, vi: req_if.var_index,
                            val: req_if.value, eod: req_if.end_of_data});
            any_accept = 1'b1;
         end
         if (csr_if.valid && csr_if.ready)
            any_accept = 1'b1;
         if (rsp_if.valid && rsp_if.ready) begin
            any_accept = 1'b1;
            got = '{pid: rsp_if.out_person_id, kind: gdma_kind_type'(rsp_if.kind),
                    vi: rsp_if.out_var_index, mean: rsp_if.mean,
                    undef: rsp_if.mean_undefined, ca: rsp_if.valid_day_count,
                    cwd: rsp_if.weekday_count, cwe: rsp_if.weekend_count,
                    qual: rsp_if.qualifies, last: rsp_if.last};
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: person 0x%0h kind %0d var %0d",
                      got.pid, got.kind, got.vi);
               fail_cnt++;
            end else begin
               exp_r = expected_q.pop_front();
               check_field("out_person_id", exp_r.pid, got.pid);
               check_field("kind", exp_r.kind, got.kind);
               check_field("out_var_index", exp_r.vi, got.vi);
               check_field("mean", exp_r.mean, got.mean);
               check_field("mean_undefined", exp_r.undef, got.undef);
               check_field("valid_day_count", exp_r.ca, got.ca);
               check_field("weekday_count", exp_r.cwd, got.cwd);
               check_field("weekend_count", exp_r.cwe, got.cwe);
               check_field("qualifies", exp_r.qual, got.qual);
               check_field("last", exp_r.last, got.last);
            end
         end
      end
      quiet_cycles = any_accept ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_item(logic [PID_W-1:0] pid, logic [DOW_W-1:0] dow, logic dv,
                            logic [VAR_W-1:0] vi, logic [VAL_W-1:0] val, logic eod);
      pending_q.push_back('{pid: pid, dow: dow, dv: dv, vi: vi, val: val, eod: eod});
   endtask

   // well-formed person: days of ordered variables, occasionally broken
   task automatic push_person(int ndays);
      logic [PID_W-1:0] pid;
      logic [DOW_W-1:0] dow;
      logic             dv;
      int               nv;
      pid = $urandom;
      for (int d = 0; d < ndays; d++) begin
         dow = DOW_W'($urandom_range(0, 7));
         dv  = ($urandom_range(0, 4) != 0);
         nv  = ($urandom_range(0, 2) == 0) ? NUM_VARS : $urandom_range(1, NUM_VARS);
         for (int v = 0; v < nv; v++)
            push_item(pid, dow, dv, VAR_W'(v), $urandom, 1'b0);
      end
      // noise: stray values, id switch mid-record, random markers
      if ($urandom_range(0, 3) == 0)
         push_item($urandom, DOW_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   VAR_W'($urandom_range(1, 15)), $urandom, 1'b0);
      if ($urandom_range(0, 4) == 0)
         push_item($urandom, DOW_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   VAR_W'($urandom_range(0, 15)), $urandom, 1'b1);
   endtask

   task automatic push_random(int count);
      int start;
      start = pending_q.size();
      while (pending_q.size() - start < count)
         push_person($urandom_range(1, 3));
   endtask

   task automatic write_min(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] d);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= d;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_MIN_VALID:   thr_valid = d;
         CSR_MIN_WEEKDAY: thr_wd    = d;
         CSR_MIN_WEEKEND: thr_we    = d;
         default: ;
      endcase
   endtask

   task automatic write_thresholds(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                   logic [CNT_W-1:0] c);
      write_min(CSR_MIN_VALID, a);
      write_min(CSR_MIN_WEEKDAY, b);
      write_min(CSR_MIN_WEEKEND, c);
   endtask

   // drain: all requests accepted, all results back, then settle
   task automatic drain();
      while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [PID_W-1:0] pid;
      reset = 1'b1;
      fail_cnt = 0;
      quiet_cycles = 0;
      start_hold = 1'b0;
      no_idle = 1'b0;
      hold_left = 0;
      req_if.valid = 1'b0;
      req_if.person_id = '0;
      req_if.day_of_week = '0;
      req_if.day_valid = 1'b0;
      req_if.var_index = '0;
      req_if.value = '0;
      req_if.end_of_data = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_MIN_VALID;
      csr_if.data = '0;
      thr_valid = 8'd1;
      thr_wd = 8'd0;
      thr_we = 8'd0;
      open_pid = '0;
      pid_open = 1'b0;
      clear_sums();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: markers and stray values with no person, extremes, id changes
      push_item('1, 3'd0, 1'b1, 4'd0, '1, 1'b1);
      push_item(32'h0, 3'd2, 1'b1, 4'd5, '1, 1'b0);
      push_item(32'h0, 3'd1, 1'b1, 4'd0, '1, 1'b0);
      push_item(32'h0, 3'd1, 1'b1, 4'd15, '1, 1'b0);
      push_item(32'h0, 3'd7, 1'b1, 4'd0, 32'h100, 1'b0);
      push_item(32'h0, 3'd0, 1'b1, 4'd0, 32'h0, 1'b0);
      push_item(32'hDEAD_BEEF, 3'd4, 1'b1, 4'd1, 32'h7, 1'b0);
      push_item(32'h0, 3'd3, 1'b0, 4'd0, '1, 1'b0);
      push_item(32'h0, 3'd6, 1'b0, 4'd2, '1, 1'b0);
      push_item('1, 3'd5, 1'b1, 4'd0, 32'h5555_5555, 1'b0);
      push_item('1, 3'd2, 1'b1, 4'd3, 32'hAAAA_AAAA, 1'b0);
      push_item('1, 3'd0, 1'b1, 4'd1, '1, 1'b1);
      push_item('1, 3'd1, 1'b1, 4'd0, '1, 1'b1);
      push_item(32'h1234_5678, 3'd7, 1'b0, 4'd0, 32'h1, 1'b0);
      push_item(32'h1234_5678, 3'd1, 1'b0, 4'd4, 32'h1, 1'b0);
      push_item(32'h8765_4321, 3'd6, 1'b1, 4'd0, 32'h300, 1'b0);
      push_item(32'h8765_4321, 3'd2, 1'b1, 4'd0, 32'h301, 1'b0);
      push_item(32'h0, 3'd0, 1'b0, 4'd0, '0, 1'b1);
      drain();

      // all thresholds at zero
      write_thresholds(8'd0, 8'd0, 8'd0);
      push_random(15);
      push_item('0, '0, 1'b0, '0, '0, 1'b1);
      drain();

      // thresholds at maximum; saturate counts, sums and the mean
      write_thresholds(8'd255, 8'd255, 8'd255);
      pid = $urandom;
      for (int i = 0; i < 262; i++)
         push_item(pid, (i % 3 == 0) ? 3'd7 : 3'd3, 1'b1, 4'd0, '1, 1'b0);
      push_item('0, '0, 1'b0, '0, '0, 1'b1);
      drain();

      // receiver holds off while the sender keeps offering
      write_thresholds(CNT_W'($urandom_range(0, 4)), CNT_W'($urandom_range(0, 3)),
                       CNT_W'($urandom_range(0, 2)));
      start_hold = 1'b1;
      push_random(25);
      push_item('0, '0, 1'b0, '0, '0, 1'b1);
      drain();

      // closing stretch with no idling
      no_idle = 1'b1;
      write_thresholds(CNT_W'($urandom_range(0, 2)), CNT_W'($urandom_range(0, 2)),
                       CNT_W'($urandom_range(0, 1)));
      push_random(15);
      push_item('0, '0, 1'b0, '0, '0, 1'b1);
      drain();

      if (fail_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
